/* rtl/core/serial_line_editor_tokenizer_top_macros.svh */
// Assertion macros for the serial line editor and tokenizer.
`ifndef SERIAL_LINE_EDITOR_TOKENIZER_TOP_MACROS_SVH
`define SERIAL_LINE_EDITOR_TOKENIZER_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SLET_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SLET_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/sletok_pkg.sv */
// Shared types, character codes and helpers for the line editor and tokenizer.
package sletok_pkg;

   localparam logic [7:0] KEY_BS           = 8'd8;
   localparam logic [7:0] KEY_DEL          = 8'd127;
   localparam logic [7:0] KEY_CR           = 8'd13;
   localparam logic [7:0] KEY_LF           = 8'd10;
   localparam logic [7:0] CHAR_FIRST_PRINT = 8'd32;
   localparam logic [7:0] CHAR_LAST_PRINT  = 8'd126;
   localparam logic [7:0] CHAR_DIGIT_0     = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9     = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A     = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z     = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A     = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z     = 8'h7A;

   localparam logic       KIND_ALPHA = 1'b0;
   localparam logic       KIND_NUM   = 1'b1;

   localparam int         VALUE_W   = 31;
   localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

   typedef struct packed {
      logic accept;
      logic scan_init;
      logic scan_run;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic line_end;
      logic scan_done;
      logic emit_last;
   } status_type;

   function automatic logic is_letter(input logic [7:0] c);
      return ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) ||
             ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z));
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHAR_DIGIT_0) && (c <= CHAR_DIGIT_9);
   endfunction

endpackage

/* rtl/core/sletok_ctrl.sv */
// Sequencing state machine: take bytes, scan the finished line, emit fields.
module sletok_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output sletok_pkg::cmd_type  cmd,
   input  sletok_pkg::status_type status
);
   import sletok_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.accept    = start;
            cmd.scan_init = start & status.line_end;
            if (start && status.line_end) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_run = 1'b1;
            if (status.scan_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            if (status.emit_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

/* rtl/core/sletok_datapath.sv */
// Line store, editing, field scan with digit accumulation, and result registers.
module sletok_datapath #(
   parameter int LINE_CAPACITY = 80,
   parameter int FIELD_LIMIT   = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             req_rx_byte,
   input  sletok_pkg::cmd_type    cmd,
   output sletok_pkg::status_type status,
   output logic                   rsp_strobe,
   output logic [2:0]             rsp_field_index,
   output logic [6:0]             rsp_field_position,
   output logic                   rsp_field_kind,
   output logic signed [31:0]     rsp_field_value,
   output logic [2:0]             rsp_total_fields,
   output logic                   rsp_no_fields,
   output logic                   rsp_line_truncated,
   output logic                   rsp_last
);
   import sletok_pkg::*;

   localparam int CW  = $clog2(LINE_CAPACITY + 1);
   localparam int AW  = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
   localparam int FCW = $clog2(FIELD_LIMIT + 1);
   localparam int FIW = (FIELD_LIMIT > 1) ? $clog2(FIELD_LIMIT) : 1;

   // line store and editing
   logic [7:0]     line_mem [LINE_CAPACITY];
   logic [CW-1:0]  count_ff;
   logic [CW-1:0]  count_in;
   logic           trunc_ff;

   // scan pipeline
   logic [CW-1:0]  rd_addr_ff, rd_addr_in;
   logic [CW-1:0]  rd_pos_ff, rd_pos_in;
   logic           rd_vld_ff, rd_vld_in;
   logic [7:0]     rd_data_ff;
   logic           rd_issue;
   logic [FCW-1:0] found_ff, found_in;
   logic           stop_ff, stop_in;
   logic           prev_delim_ff, prev_delim_in;
   logic           in_digits_ff, in_digits_in;
   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic [FIW-1:0] cur_idx_ff, cur_idx_in;
   logic [FIW-1:0] emit_idx_ff, emit_idx_in;

   // per-field records
   logic [CW-1:0]      fpos_ff  [FIELD_LIMIT];
   logic               fkind_ff [FIELD_LIMIT];
   logic [VALUE_W-1:0] fval_ff  [FIELD_LIMIT];
   logic               start_we;
   logic               val_we;
   logic [FIW-1:0]     wr_idx;
   logic [VALUE_W-1:0] wr_val;

   logic           b_erase, b_eol, b_print, full;
   logic           c_alpha, c_num, c_word;
   logic [3:0]     c_digit;
   logic [VALUE_W+3:0] acc_wide;
   logic [VALUE_W-1:0] acc_sat;
   logic [FCW-1:0] emit_next;
   logic           emit_last;
   logic [FIW+2:0] idx_ext;
   logic [FCW+2:0] total_ext;
   logic [CW+6:0]  pos_ext;

   assign b_erase = (req_rx_byte == KEY_BS) || (req_rx_byte == KEY_DEL);
   assign b_eol   = (req_rx_byte == KEY_CR) || (req_rx_byte == KEY_LF);
   assign b_print = (req_rx_byte >= CHAR_FIRST_PRINT) && (req_rx_byte <= CHAR_LAST_PRINT);
   assign full    = (count_ff == CW'(LINE_CAPACITY));

   assign status.line_end  = b_eol || (b_print && full);
   assign rd_issue         = cmd.scan_run && (rd_addr_ff < count_ff);
   assign status.scan_done = stop_ff || (!rd_vld_ff && !(rd_addr_ff < count_ff));

   assign emit_next        = FCW'(emit_idx_ff) + FCW'(1);
   assign emit_last        = (found_ff == '0) || (emit_next == found_ff);
   assign status.emit_last = emit_last;

   // character class of the byte coming back from the store
   assign c_alpha  = is_letter(rd_data_ff);
   assign c_num    = is_digit(rd_data_ff);
   assign c_word   = c_alpha || c_num;
   assign c_digit  = rd_data_ff[3:0];
   assign acc_wide = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1)
                   + {{VALUE_W{1'b0}}, c_digit};
   assign acc_sat  = (acc_wide > {4'b0, VALUE_MAX}) ? VALUE_MAX : acc_wide[VALUE_W-1:0];

   // editing
   always_comb begin
      count_in = count_ff;
      if (cmd.accept) begin
         if (b_erase && (count_ff != '0)) begin
            count_in = count_ff - CW'(1);
         end else if (b_print && !full) begin
            count_in = count_ff + CW'(1);
         end
      end
      if (cmd.emit && emit_last) begin
         count_in = '0;
      end
   end

   // scan
   always_comb begin
      rd_addr_in    = rd_addr_ff;
      rd_pos_in     = rd_pos_ff;
      rd_vld_in     = 1'b0;
      found_in      = found_ff;
      stop_in       = stop_ff;
      prev_delim_in = prev_delim_ff;
      in_digits_in  = in_digits_ff;
      acc_in        = acc_ff;
      cur_idx_in    = cur_idx_ff;
      emit_idx_in   = emit_idx_ff;
      start_we      = 1'b0;
      val_we        = 1'b0;
      wr_idx        = cur_idx_ff;
      wr_val        = acc_sat;
      if (cmd.scan_init) begin
         rd_addr_in    = '0;
         found_in      = '0;
         stop_in       = 1'b0;
         prev_delim_in = 1'b1;
         in_digits_in  = 1'b0;
         emit_idx_in   = '0;
      end else if (cmd.scan_run) begin
         if (rd_issue) begin
            rd_addr_in = rd_addr_ff + CW'(1);
            rd_pos_in  = rd_addr_ff;
            rd_vld_in  = 1'b1;
         end
         if (rd_vld_ff && !stop_ff) begin
            if (prev_delim_ff && c_word) begin
               if (found_ff == FCW'(FIELD_LIMIT)) begin
                  stop_in = 1'b1;
               end else begin
                  start_we     = 1'b1;
                  val_we       = 1'b1;
                  wr_idx       = found_ff[FIW-1:0];
                  wr_val       = c_num ? {{(VALUE_W-4){1'b0}}, c_digit} : '0;
                  acc_in       = wr_val;
                  cur_idx_in   = found_ff[FIW-1:0];
                  in_digits_in = c_num;
                  found_in     = found_ff + FCW'(1);
               end
            end else if (in_digits_ff && c_num) begin
               val_we = 1'b1;
               acc_in = acc_sat;
            end else if (!c_num) begin
               in_digits_in = 1'b0;
            end
            prev_delim_in = !c_word;
         end
      end else if (cmd.emit) begin
         emit_idx_in = emit_idx_ff + FIW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         found_ff  <= '0;
         rd_vld_ff <= 1'b0;
         stop_ff   <= 1'b0;
         rsp_strobe <= 1'b0;
      end else begin
         count_ff  <= count_in;
         found_ff  <= found_in;
         rd_vld_ff <= rd_vld_in;
         stop_ff   <= stop_in;
         rsp_strobe <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff    <= rd_addr_in;
      rd_pos_ff     <= rd_pos_in;
      prev_delim_ff <= prev_delim_in;
      in_digits_ff  <= in_digits_in;
      acc_ff        <= acc_in;
      cur_idx_ff    <= cur_idx_in;
      emit_idx_ff   <= emit_idx_in;
      if (cmd.scan_init) begin
         trunc_ff <= b_print;
      end
   end

   // line store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.accept && b_print && !full) begin
         line_mem[count_ff[AW-1:0]] <= req_rx_byte;
      end
      if (rd_issue) begin
         rd_data_ff <= line_mem[rd_addr_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (start_we) begin
         fpos_ff[wr_idx]  <= rd_pos_ff;
         fkind_ff[wr_idx] <= c_num ? KIND_NUM : KIND_ALPHA;
      end
      if (val_we) begin
         fval_ff[wr_idx] <= wr_val;
      end
   end

   assign idx_ext   = {3'b0, emit_idx_ff};
   assign total_ext = {3'b0, found_ff};
   assign pos_ext   = {7'b0, fpos_ff[emit_idx_ff]};

   // result registers
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_line_truncated <= trunc_ff;
         rsp_last           <= emit_last;
         rsp_total_fields   <= total_ext[2:0];
         if (found_ff == '0) begin
            rsp_no_fields      <= 1'b1;
            rsp_field_index    <= '0;
            rsp_field_position <= '0;
            rsp_field_kind     <= KIND_ALPHA;
            rsp_field_value    <= '0;
         end else begin
            rsp_no_fields      <= 1'b0;
            rsp_field_index    <= idx_ext[2:0];
            rsp_field_position <= pos_ext[6:0];
            rsp_field_kind     <= fkind_ff[emit_idx_ff];
            rsp_field_value    <= (fkind_ff[emit_idx_ff] == KIND_NUM) ?
                                  {1'b0, fval_ff[emit_idx_ff]} : '0;
         end
      end
   end

endmodule

/* rtl/core/serial_line_editor_tokenizer_top.sv */
// Top level of the serial line editor and field tokenizer.
// Usage: present a received byte on req_rx_byte with start high; it is taken
// at the rising edge where start is high and busy is low. Backspace and
// delete drop the last stored character, printable bytes are stored, other
// bytes are ignored. An editing byte leaves busy low.
// CR, LF, or a printable byte while the store is full ends the line: busy
// rises, the store is scanned one character per cycle through its
// registered read port, then one result per field leaves on consecutive
// cycles, each marked by rsp_strobe for one cycle; rsp_last marks the final
// one. A line without fields gives a single result with rsp_no_fields set.
// After a line end busy stays high until the last result is registered,
// and that result sits on the ports in the cycle in which busy is first low.
// The receiver cannot stall: every strobed transaction is taken at the edge
// that ends its cycle. Reset (synchronous, active high) empties the line,
// returns the controller to idle and drops any pending result.
module serial_line_editor_tokenizer_top #(
   parameter int LINE_CAPACITY = 80,
   parameter int FIELD_LIMIT   = 5
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_strobe,
   output logic [2:0]         rsp_field_index,
   output logic [6:0]         rsp_field_position,
   output logic               rsp_field_kind,
   output logic signed [31:0] rsp_field_value,
   output logic [2:0]         rsp_total_fields,
   output logic               rsp_no_fields,
   output logic               rsp_line_truncated,
   output logic               rsp_last
);
   import sletok_pkg::*;

`include "serial_line_editor_tokenizer_top_macros.svh"

   cmd_type    cmd;
   status_type status;

   // Controller: idle / scan / emit sequencing only.
   sletok_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .cmd    (cmd),
      .status (status)
   );

   // Datapath: store, scan pipeline, field records and result registers.
   sletok_datapath #(
      .LINE_CAPACITY (LINE_CAPACITY),
      .FIELD_LIMIT   (FIELD_LIMIT)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_rx_byte        (req_rx_byte),
      .cmd                (cmd),
      .status             (status),
      .rsp_strobe         (rsp_strobe),
      .rsp_field_index    (rsp_field_index),
      .rsp_field_position (rsp_field_position),
      .rsp_field_kind     (rsp_field_kind),
      .rsp_field_value    (rsp_field_value),
      .rsp_total_fields   (rsp_total_fields),
      .rsp_no_fields      (rsp_no_fields),
      .rsp_line_truncated (rsp_line_truncated),
      .rsp_last           (rsp_last)
   );

   // Hold the strobe low after the final transaction of a line.
   `SLET_ASSERT_NEXT(a_last_ends_burst, rsp_strobe && rsp_last, !rsp_strobe, "result after last")
   // Advance the field number by one through a line's results.
   `SLET_ASSERT_NEXT(a_index_steps, rsp_strobe && !rsp_last,
      rsp_strobe && (rsp_field_index == $past(rsp_field_index) + 3'd1), "field gap")
   // An empty line gives exactly one final result with no fields counted.
   `SLET_ASSERT_IMP(a_empty_line, rsp_strobe && rsp_no_fields,
      rsp_last && (rsp_total_fields == 3'd0), "bad empty-line result")
   // Busy only rises after a byte was taken.
   `SLET_ASSERT_IMP(a_busy_from_accept, $rose(busy), $past(start), "busy without start")

endmodule
